FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/cce_pkg.sv
package cce_pkg;

  localparam int unsigned MAX_ORDER_DEF = 32;
  localparam int unsigned ADDR_W        = 5;

  localparam logic [5:0]  ORDER_RESET    = 6'd8;
  localparam logic [31:0] POLY_RESET     = 32'h0000_0031;
  localparam logic [31:0] INIT_RESET     = 32'h0000_0000;
  localparam logic [31:0] FXOR_RESET     = 32'h0000_0000;
  localparam logic        REFL_IN_RESET  = 1'b1;
  localparam logic        REFL_OUT_RESET = 1'b1;
  localparam logic        LSB_RESET      = 1'b0;

  localparam logic [2:0] REG_ORDER    = 3'd0;
  localparam logic [2:0] REG_POLY     = 3'd1;
  localparam logic [2:0] REG_INIT     = 3'd2;
  localparam logic [2:0] REG_FXOR     = 3'd3;
  localparam logic [2:0] REG_REFL_IN  = 3'd4;
  localparam logic [2:0] REG_REFL_OUT = 3'd5;
  localparam logic [2:0] REG_LSB      = 3'd6;

  typedef struct packed {
    logic [5:0]  order;
    logic [31:0] mask;
    logic [31:0] poly;
    logic [31:0] init;
    logic [31:0] fxor;
    logic        refl_in;
    logic        refl_out;
    logic        lsb;
  } cce_cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cce_ctl_t;

  function automatic logic [31:0] cce_reflect(input logic [31:0] v, input logic [5:0] n);
    logic [31:0] r;
    r = {<<{v}};
    return r >> (6'd32 - n);
  endfunction

  function automatic logic [5:0] cce_cap_count(input logic [5:0] cnt);
    return (cnt > 6'd32) ? 6'd32 : cnt;
  endfunction

endpackage

FILE: rtl/core/cce_regs.sv
module cce_regs #(
  parameter int unsigned MAX_ORDER = cce_pkg::MAX_ORDER_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [cce_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output cce_pkg::cce_cfg_t         cfg
);
  import cce_pkg::*;

  logic [5:0]  order_r;
  logic [31:0] poly_r;
  logic [31:0] init_r;
  logic [31:0] fxor_r;
  logic        refl_in_r;
  logic        refl_out_r;
  logic        lsb_r;

  logic [2:0]  idx;
  logic        wr;
  logic [5:0]  order_eff;
  logic [31:0] mask;

  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= ORDER_RESET;
      poly_r     <= POLY_RESET;
      init_r     <= INIT_RESET;
      fxor_r     <= FXOR_RESET;
      refl_in_r  <= REFL_IN_RESET;
      refl_out_r <= REFL_OUT_RESET;
      lsb_r      <= LSB_RESET;
    end else if (wr) begin
      case (idx)
        REG_ORDER:    order_r    <= cfg_pwdata[5:0];
        REG_POLY:     poly_r     <= cfg_pwdata;
        REG_INIT:     init_r     <= cfg_pwdata;
        REG_FXOR:     fxor_r     <= cfg_pwdata;
        REG_REFL_IN:  refl_in_r  <= cfg_pwdata[0];
        REG_REFL_OUT: refl_out_r <= cfg_pwdata[0];
        REG_LSB:      lsb_r      <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORDER:    cfg_prdata = {26'd0, order_r};
      REG_POLY:     cfg_prdata = poly_r;
      REG_INIT:     cfg_prdata = init_r;
      REG_FXOR:     cfg_prdata = fxor_r;
      REG_REFL_IN:  cfg_prdata = {31'd0, refl_in_r};
      REG_REFL_OUT: cfg_prdata = {31'd0, refl_out_r};
      REG_LSB:      cfg_prdata = {31'd0, lsb_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (order_r == 6'd0) begin
      order_eff = 6'd1;
    end else if (order_r > 6'(MAX_ORDER)) begin
      order_eff = 6'(MAX_ORDER);
    end else begin
      order_eff = order_r;
    end
  end

  assign mask = 32'hFFFF_FFFF >> (6'd32 - order_eff);

  assign cfg.order    = order_eff;
  assign cfg.mask     = mask;
  assign cfg.poly     = poly_r & mask;
  assign cfg.init     = init_r & mask;
  assign cfg.fxor     = fxor_r;
  assign cfg.refl_in  = refl_in_r;
  assign cfg.refl_out = refl_out_r;
  assign cfg.lsb      = lsb_r;

endmodule

FILE: rtl/core/cce_seq.sv
module cce_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [5:0]        in_data_count,
  input  logic              out_free,
  output logic              in_stall,
  output cce_pkg::cce_ctl_t ctl
);
  import cce_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOLD = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [5:0] left_r, left_nxt;
  logic [5:0] cap;

  assign cap      = cce_cap_count(in_data_count);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          left_nxt  = cap;
          state_nxt = (cap == 6'd0) ? S_DONE : S_FOLD;
        end
      end
      S_FOLD: begin
        ctl.step = 1'b1;
        left_nxt = left_r - 6'd1;
        if (left_r == 6'd1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= 6'd0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

FILE: rtl/core/cce_lfsr.sv
module cce_lfsr #(
  parameter int unsigned MAX_ORDER = cce_pkg::MAX_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cce_pkg::cce_ctl_t    ctl,
  input  cce_pkg::cce_cfg_t    cfg,
  input  logic [31:0]          in_data_bits,
  input  logic [5:0]           in_data_count,
  input  logic                 in_restart,
  output logic [MAX_ORDER-1:0] rem
);
  import cce_pkg::*;

  logic [MAX_ORDER-1:0] state_r;
  logic [31:0]          data_r;
  logic [4:0]           idx_r;

  logic        asc;
  logic [5:0]  cap;
  logic [31:0] rem_ext;
  logic [31:0] start;
  logic [31:0] tb;
  logic        b;
  logic        top;
  logic        fb;
  logic [31:0] fold_nxt;

  assign asc     = cfg.refl_in ^ cfg.lsb;
  assign cap     = cce_cap_count(in_data_count);
  assign rem_ext = 32'(state_r);
  assign tb      = cfg.mask & ~(cfg.mask >> 1);
  assign b       = data_r[idx_r];
  assign top     = |(rem_ext & tb);
  assign fb      = rem_ext[0] ^ b;

  always_comb begin
    if (in_restart) begin
      start = cfg.refl_in ? cce_reflect(cfg.init, cfg.order) : cfg.init;
    end else begin
      start = rem_ext & cfg.mask;
    end
  end

  always_comb begin
    if (cfg.lsb) begin
      fold_nxt = (rem_ext >> 1) ^ (fb ? cfg.poly : 32'd0);
    end else begin
      fold_nxt = ((rem_ext << 1) & cfg.mask) ^ ((top ^ b) ? cfg.poly : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (ctl.load) begin
      state_r <= start[MAX_ORDER-1:0];
    end else if (ctl.step) begin
      state_r <= fold_nxt[MAX_ORDER-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= in_data_bits;
      idx_r  <= asc ? 5'd0 : 5'(cap - 6'd1);
    end else if (ctl.step) begin
      idx_r  <= asc ? (idx_r + 5'd1) : (idx_r - 5'd1);
    end
  end

  assign rem = state_r;

endmodule

FILE: rtl/core/cce_out.sv
module cce_out #(
  parameter int unsigned MAX_ORDER = cce_pkg::MAX_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cce_pkg::cce_ctl_t    ctl,
  input  cce_pkg::cce_cfg_t    cfg,
  input  logic [MAX_ORDER-1:0] rem,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [31:0]          out_crc_value,
  output logic                 out_free
);
  import cce_pkg::*;

  logic        valid_r;
  logic [31:0] crc_r;
  logic [31:0] rem_ext;
  logic [31:0] val;

  assign rem_ext  = 32'(rem);
  assign val      = cfg.refl_out ? cce_reflect(rem_ext, cfg.order) : rem_ext;
  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.emit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      crc_r <= (val ^ cfg.fxor) & cfg.mask;
    end
  end

  assign out_valid     = valid_r;
  assign out_crc_value = crc_r;

endmodule

FILE: rtl/core/configurable_crc_engine.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_data_bits, in_data_count, in_restart
// out_      output     out_valid / out_stall out_crc_value
// cfg_      config     APB write, pready=1   cfg_paddr, cfg_pwdata, cfg_prdata
//
// Each item is loaded, folded by the one-bit loop once per data bit (at most 32),
// then emitted once the output register is free; no new item is taken before that.
// The result waits in the output register; the next item is taken while it waits.
// Synchronous active-low reset clears the remainder to zero and loads the
// register defaults; there is no clearing pass.
`include "assert_macros.svh"
module configurable_crc_engine #(
  parameter int unsigned MAX_ORDER = cce_pkg::MAX_ORDER_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                in_data_bits,
  input  logic [5:0]                 in_data_count,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_crc_value,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cce_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import cce_pkg::*;

  cce_cfg_t             cfg;
  cce_ctl_t             ctl;
  logic [MAX_ORDER-1:0] rem;
  logic                 out_free;

  cce_regs #(.MAX_ORDER(MAX_ORDER)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cce_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data_count (in_data_count),
    .out_free      (out_free),
    .in_stall      (in_stall),
    .ctl           (ctl)
  );

  cce_lfsr #(.MAX_ORDER(MAX_ORDER)) u_lfsr (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg),
    .in_data_bits  (in_data_bits),
    .in_data_count (in_data_count),
    .in_restart    (in_restart),
    .rem           (rem)
  );

  cce_out #(.MAX_ORDER(MAX_ORDER)) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg),
    .rem           (rem),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_crc_value (out_crc_value),
    .out_free      (out_free)
  );

  `ASSERT_NEXT(a_stall_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLY(a_emit_into_free_slot, clk, rst_n, ctl.emit, !out_valid || !out_stall)
  `ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, ctl.emit, out_valid)

endmodule

FILE: tb/crc_checker.sv
`timescale 1ns / 100ps

module crc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [31:0]                in_data_bits,
  input  logic [5:0]                 in_data_count,
  input  logic                       in_restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [31:0]                out_crc_value,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cce_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         fail_count,
  output int                         pending
);
  import cce_pkg::*;

  logic [5:0]  order_q;
  logic [31:0] poly_q;
  logic [31:0] init_q;
  logic [31:0] fxor_q;
  logic        refl_in_q;
  logic        refl_out_q;
  logic        lsb_q;
  logic [31:0] remainder_q;
  logic [31:0] crc_due[$];

  function automatic logic [31:0] flip_low(input logic [31:0] v, input int n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[i] = v[n-1-i];
    return r;
  endfunction

  function automatic logic [31:0] fold_item(input logic [31:0] d, input logic [5:0] c_raw,
                                            input logic rs);
    int          n;
    int          cnt;
    logic [31:0] mask;
    logic [31:0] poly;
    logic [31:0] data;
    logic [31:0] st;
    logic [31:0] val;
    logic        fb;
    logic        top;
    n = int'(order_q);
    if (n < 1) n = 1;
    if (n > int'(MAX_ORDER_DEF)) n = int'(MAX_ORDER_DEF);
    if (n > 32) n = 32;
    mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    poly = poly_q & mask;
    cnt = (int'(c_raw) > 32) ? 32 : int'(c_raw);
    data = d & ((cnt >= 32) ? 32'hFFFF_FFFF : ((32'd1 << cnt) - 32'd1));
    if (rs) begin
      remainder_q = init_q & mask;
      if (refl_in_q) remainder_q = flip_low(remainder_q, n);
    end
    st = remainder_q & mask;
    if (refl_in_q) data = flip_low(data, cnt);
    if (lsb_q) begin
      for (int i = 0; i < cnt; i++) begin
        fb = st[0] ^ data[0];
        st = st >> 1;
        if (fb) st = st ^ poly;
        data = data >> 1;
      end
    end else begin
      for (int i = cnt; i > 0; i--) begin
        top = st[n-1];
        st = (st << 1) & mask;
        if (top ^ data[i-1]) st = st ^ poly;
      end
    end
    remainder_q = st & mask;
    val = remainder_q;
    if (refl_out_q) val = flip_low(val, n);
    return (val ^ fxor_q) & mask;
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      order_q     <= ORDER_RESET;
      poly_q      <= POLY_RESET;
      init_q      <= INIT_RESET;
      fxor_q      <= FXOR_RESET;
      refl_in_q   <= REFL_IN_RESET;
      refl_out_q  <= REFL_OUT_RESET;
      lsb_q       <= LSB_RESET;
      remainder_q = '0;
      crc_due.delete();
      fail_count  <= 0;
      pending     <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_ORDER:    order_q    <= cfg_pwdata[5:0];
          REG_POLY:     poly_q     <= cfg_pwdata;
          REG_INIT:     init_q     <= cfg_pwdata;
          REG_FXOR:     fxor_q     <= cfg_pwdata;
          REG_REFL_IN:  refl_in_q  <= cfg_pwdata[0];
          REG_REFL_OUT: refl_out_q <= cfg_pwdata[0];
          REG_LSB:      lsb_q      <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) crc_due.push_back(fold_item(in_data_bits, in_data_count,
                                                            in_restart));
      if (out_valid && !out_stall) begin
        if (crc_due.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $realtime, out_crc_value);
          fail_count <= fail_count + 1;
        end else begin
          want = crc_due.pop_front();
          if (out_crc_value !== want) begin
            $display("%0t crc_value mismatch: expected %h actual %h", $realtime, want,
                     out_crc_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= crc_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import cce_pkg::*;

  localparam int ITEM_TARGET    = 1250;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [31:0]         in_data_bits = '0;
  logic [5:0]          in_data_count = 6'd1;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [31:0]         out_crc_value;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  int                  fail_count;
  int                  pending;
  int                  idle_mode = 0;
  int                  quiet = 0;
  int                  sent = 0;

  configurable_crc_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_bits  (in_data_bits),
    .in_data_count (in_data_count),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  crc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_bits  (in_data_bits),
    .in_data_count (in_data_count),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    case (idle_mode)
      0:       out_stall <= ($urandom_range(0, 99) < 78);
      1:       out_stall <= ($urandom_range(0, 99) < 32);
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL configurable_crc_engine");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [5:0] order, input logic [31:0] poly,
                               input logic [31:0] init, input logic [31:0] fxor,
                               input logic ri, input logic ro, input logic lsb);
    in_valid <= 1'b0;
    drain();
    reg_write(REG_ORDER, {26'd0, order});
    reg_write(REG_POLY, poly);
    reg_write(REG_INIT, init);
    reg_write(REG_FXOR, fxor);
    reg_write(REG_REFL_IN, {31'd0, ri});
    reg_write(REG_REFL_OUT, {31'd0, ro});
    reg_write(REG_LSB, {31'd0, lsb});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [31:0] d, input logic [5:0] c, input logic rs);
    int pct;
    pct = (idle_mode == 0) ? 32 : (idle_mode == 1) ? 78 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_bits  <= d;
    in_data_count <= c;
    in_restart    <= rs;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [31:0] pick_word;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_order;
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd32;
      3:       return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [5:0] pick_count;
    case ($urandom_range(0, 19))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    int          phase_items;
    int          msg_len;
    logic        rs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(32'h0000_00A5, 6'd8, 1'b0);
    send_item(32'h0000_0031, 6'd8, 1'b1);
    send_item(32'h0000_0001, 6'd1, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd32, 1'b0);
    send_item(32'h0000_0000, 6'd32, 1'b0);
    send_item(32'hFFFF_FFFF, 6'd0, 1'b0);
    send_item(32'hA5A5_5A5A, 6'd63, 1'b0);
    send_item(32'h1234_5678, 6'd33, 1'b1);

    load_settings(6'd32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    send_item(32'h0000_0031, 6'd8, 1'b1);
    send_item(32'h0000_0032, 6'd8, 1'b0);
    send_item(32'h0000_0033, 6'd8, 1'b0);
    send_item(32'hDEAD_BEEF, 6'd32, 1'b0);

    load_settings(6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    send_item(32'h0000_0015, 6'd5, 1'b1);
    send_item(32'hFFFF_FFFF, 6'd32, 1'b0);

    load_settings(6'd63, 32'hEDB8_8320, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
    send_item(32'h0000_ABCD, 6'd16, 1'b1);
    send_item(32'h8000_0001, 6'd32, 1'b0);
    send_item(32'h0000_007F, 6'd7, 1'b0);

    load_settings(6'd1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b1, 1'b0);
    send_item(32'h000F_0F0F, 6'd20, 1'b1);
    send_item(32'hFFFF_FFFF, 6'd32, 1'b0);

    while (sent < ITEM_TARGET) begin
      load_settings(pick_order(), pick_word(), pick_word(), pick_word(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      phase_items = $urandom_range(30, 90);
      while (phase_items > 0 && sent < ITEM_TARGET) begin
        msg_len = $urandom_range(1, 12);
        for (int j = 0; j < msg_len; j++) begin
          idle_mode = (sent < ITEM_TARGET / 3) ? 0 : (sent < 2 * ITEM_TARGET / 3) ? 1 : 2;
          if (j == 0) rs = ($urandom_range(0, 19) != 0);
          else rs = ($urandom_range(0, 29) == 0);
          send_item($urandom, pick_count(), rs);
          phase_items--;
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS configurable_crc_engine");
    end else begin
      $display("FAIL configurable_crc_engine");
    end
    $finish;
  end

endmodule
